// ===== sv/set_assoc_writeback_cache_lru_defines.svh =====
// ----------------------------------------------------------------------------
// Set-associative write-back cache: assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_WRITEBACK_CACHE_LRU_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_CACHE_LRU_DEFINES_SVH
`ifndef SYNTHESIS
`define SACL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sacl assertion failed");
`define SACL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sacl assertion failed");
`else
`define SACL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SACL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// Set-associative write-back cache: package
// Request and result types, codes and fixed widths.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int REQ_DATA_BITS = 104;
   localparam int RSP_DATA_BITS = 112;
   localparam int MODE_BITS     = 2;
   localparam int KIND_BITS     = 3;

   localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FILL  = 2'd2;

   localparam logic [1:0] ST_INV   = 2'd0;
   localparam logic [1:0] ST_CLEAN = 2'd1;
   localparam logic [1:0] ST_DIRTY = 2'd2;

   typedef enum logic [1:0] {
      CLS_READ, CLS_WRITE, CLS_FILL, CLS_BAD
   } cls_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_READ  = 3'd0,
      KIND_WRITE = 3'd1,
      KIND_WB    = 3'd2,
      KIND_FREQ  = 3'd3,
      KIND_REJ   = 3'd4
   } kind_type;

   typedef struct packed {
      cls_type     cls;
      logic [31:0] addr;
      logic [7:0]  wbyte;
      logic [63:0] fword;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  rbyte;
      logic        hit;
      logic [31:0] maddr;
      logic [63:0] mword;
      logic        last;
   } rsp_type;

endpackage

// ===== sv/set_assoc_writeback_cache_lru.sv =====
// Read hit: S_IDLE, S_LOOK, S_RDOUT; write hit: S_IDLE, S_LOOK; one at a time.
// Miss: S_WBRD, S_WBOUT per write-back word of a dirty victim, then fill request;
// fill words are written in S_IDLE; the last adds S_FUPD (S_RDOUT on reads).
// The steps follow the registered set-row read and the registered data RAM read.
// Synchronous active-high reset; per-set valid flops clear tags, ages and
// status at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Set-associative write-back cache: top level
// Front queue, cache back end and response queue on stream ports.
// ----------------------------------------------------------------------------
`include "set_assoc_writeback_cache_lru_defines.svh"

module set_assoc_writeback_cache_lru #(
   parameter int WAYS        = 8,
   parameter int INDEX_BITS  = 6,
   parameter int OFFSET_BITS = 6,
   parameter int ADDR_BITS   = 32,
   parameter int AGE_BITS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // address[31:0], write_byte[39:32], fill_word[103:40]
   input  logic [sacl_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode
   input  logic [sacl_pkg::MODE_BITS-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_byte[7:0], hit[8], mem_address[40:9], mem_word[104:41], zero pad
   output logic [sacl_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // kind
   output logic [sacl_pkg::KIND_BITS-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);
   import sacl_pkg::*;

   req_type q_head;
   logic    q_valid, q_pop;
   rsp_type rsp_item, rsp_head;
   logic    rsp_push, rsp_full, rsp_empty;
   logic [$bits(rsp_type)-1:0] rsp_dout;

   sacl_front #(.ADDR_BITS(ADDR_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_head     (q_head),
      .q_valid    (q_valid),
      .q_pop      (q_pop)
   );

   sacl_back #(
      .WAYS        (WAYS),
      .INDEX_BITS  (INDEX_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .ADDR_BITS   (ADDR_BITS),
      .AGE_BITS    (AGE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .rsp_item (rsp_item),
      .rsp_push (rsp_push),
      .rsp_full (rsp_full)
   );

   sacl_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_item),
      .pop   (rsp_tvalid && rsp_tready),
      .dout  (rsp_dout),
      .full  (rsp_full),
      .empty (rsp_empty)
   );

   assign rsp_head   = rsp_dout;
   assign rsp_tvalid = !rsp_empty;
   assign rsp_tuser  = rsp_head.kind;
   assign rsp_tlast  = rsp_head.last;
   assign rsp_tdata  = {7'd0, rsp_head.mword, rsp_head.maddr, rsp_head.hit, rsp_head.rbyte};

   `SACL_ASSERT_IMP(a_no_rsp_overflow, clock, reset, rsp_push, !rsp_full)
   `SACL_ASSERT_IMP(a_pop_needs_item, clock, reset, q_pop, q_valid)
   `SACL_ASSERT_NXT(a_wb_holds_queue, clock, reset,
      rsp_push && rsp_item.kind == KIND_WB && !rsp_item.last, !q_pop)
endmodule

// ===== sv/sacl_fifo.sv =====
// ----------------------------------------------------------------------------
// Set-associative write-back cache: small FIFO
// Register-based first-word-fall-through queue.
// ----------------------------------------------------------------------------
module sacl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full  = (count_ff == (PW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end
endmodule

// ===== sv/sacl_front.sv =====
// ----------------------------------------------------------------------------
// Set-associative write-back cache: front end
// Accepts requests, classifies the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module sacl_front #(
   parameter int ADDR_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // address[31:0], write_byte[39:32], fill_word[103:40]
   input  logic [sacl_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // mode
   input  logic [sacl_pkg::MODE_BITS-1:0]     req_tuser,
   output sacl_pkg::req_type                  q_head,
   output logic                                q_valid,
   input  logic                                q_pop
);
   import sacl_pkg::*;

   localparam logic [31:0] ADDR_MASK =
      (ADDR_BITS >= 32) ? '1 : 32'((64'd1 << ADDR_BITS) - 64'd1);

   req_type                item;
   logic                   full, empty, push;
   logic [$bits(req_type)-1:0] q_dout;

   always_comb begin
      item       = '0;
      item.addr  = req_tdata[31:0] & ADDR_MASK;
      item.wbyte = req_tdata[39:32];
      item.fword = req_tdata[103:40];
      unique case (req_tuser)
         MODE_READ:  item.cls = CLS_READ;
         MODE_WRITE: item.cls = CLS_WRITE;
         MODE_FILL:  item.cls = CLS_FILL;
         default:    item.cls = CLS_BAD;
      endcase
   end

   assign req_tready = !full;
   assign push       = req_tvalid && !full;
   assign q_valid    = !empty;
   assign q_head     = q_dout;

   sacl_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_req_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (item),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (full),
      .empty (empty)
   );
endmodule

// ===== sv/sacl_back.sv =====
// ----------------------------------------------------------------------------
// Set-associative write-back cache: back end
// Tag/age/status lookup, LRU victim choice, write-back and fill sequencing.
// ----------------------------------------------------------------------------
module sacl_back #(
   parameter int WAYS        = 8,
   parameter int INDEX_BITS  = 6,
   parameter int OFFSET_BITS = 6,
   parameter int ADDR_BITS   = 32,
   parameter int AGE_BITS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  sacl_pkg::req_type q_head,
   input  logic              q_valid,
   output logic              q_pop,
   output sacl_pkg::rsp_type rsp_item,
   output logic              rsp_push,
   input  logic              rsp_full
);
   import sacl_pkg::*;

   localparam int SETS      = 1 << INDEX_BITS;
   localparam int LW        = 1 << (OFFSET_BITS - 3);
   localparam int WB        = (OFFSET_BITS > 3) ? OFFSET_BITS - 3 : 1;
   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINES     = SETS * WAYS;
   localparam int LINE_BITS = $clog2(LINES);
   localparam int LB1       = LINE_BITS + 1;
   localparam int DATA_BITS = $clog2(LINES * LW);
   localparam int DB1       = DATA_BITS + 1;
   localparam int TAG_BITS  = ADDR_BITS - INDEX_BITS - OFFSET_BITS;
   localparam int ENT       = 2 + TAG_BITS + AGE_BITS;
   localparam int ROW       = WAYS * ENT;
   localparam logic [AGE_BITS-1:0] AGE_MAX   = '1;
   localparam logic [WB-1:0]       LAST_WORD = WB'(LW - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_LOOK, S_RDOUT, S_WBRD, S_WBOUT, S_FREQ, S_FUPD
   } state_type;

   function automatic logic [ADDR_BITS-1:0] ext(input logic [31:0] a);
      return ADDR_BITS'({{ADDR_BITS{1'b0}}, a});
   endfunction

   function automatic logic [INDEX_BITS-1:0] get_set(input logic [31:0] a);
      logic [ADDR_BITS-1:0] e;
      e = ext(a);
      return e[OFFSET_BITS +: INDEX_BITS];
   endfunction

   function automatic logic [TAG_BITS-1:0] get_tag(input logic [31:0] a);
      logic [ADDR_BITS-1:0] e;
      e = ext(a);
      return e[ADDR_BITS-1 -: TAG_BITS];
   endfunction

   function automatic logic [WB-1:0] get_word(input logic [31:0] a);
      logic [7:0] o;
      o = a[7:0] & 8'((16'd1 << OFFSET_BITS) - 16'd1);
      return WB'(o >> 3);
   endfunction

   function automatic logic [DATA_BITS-1:0] data_idx(input logic [INDEX_BITS-1:0] s,
                                                     input logic [WAY_BITS-1:0] w,
                                                     input logic [WB-1:0] wd);
      logic [LB1-1:0] l;
      logic [DB1-1:0] d;
      l = LB1'(s) * LB1'(WAYS) + LB1'(w);
      d = DB1'(l[LINE_BITS-1:0]) * DB1'(LW) + DB1'(wd);
      return d[DATA_BITS-1:0];
   endfunction

   function automatic logic [31:0] vic_addr(input logic [TAG_BITS-1:0] t,
                                            input logic [INDEX_BITS-1:0] s);
      logic [ADDR_BITS-1:0] e;
      e = {t, s, {OFFSET_BITS{1'b0}}};
      return 32'({{32{1'b0}}, e});
   endfunction

   // storage
   logic [ROW-1:0] set_mem [SETS];
   logic [63:0]    data_mem [LINES * LW];
   logic [SETS-1:0] rowv_ff;
   logic [ROW-1:0] row_rd_ff;
   logic           rowv_rd_ff;
   logic [63:0]    data_rd_ff;

   // memory controls
   logic                  row_re, row_we;
   logic [INDEX_BITS-1:0] row_raddr, row_waddr;
   logic [ROW-1:0]        row_wdata;
   logic                  data_re, data_we;
   logic [DATA_BITS-1:0]  data_raddr, data_waddr;
   logic [63:0]           data_wdata;
   logic [7:0]            data_be;

   // control and payload registers
   state_type             state_ff, state_in;
   logic                  miss_ff, miss_in;
   logic [WB-1:0]         fill_cnt_ff, fill_cnt_in;
   logic [WAY_BITS-1:0]   pend_way_ff, pend_way_in;
   req_type               cur_ff, cur_in;
   logic [WB-1:0]         cnt_ff, cnt_in;
   logic [WAY_BITS-1:0]   way_ff, way_in;
   logic [31:0]           vaddr_ff, vaddr_in;
   logic [31:0]           pend_addr_ff, pend_addr_in;
   logic                  pend_wr_ff, pend_wr_in;
   logic [7:0]            pend_byte_ff, pend_byte_in;
   logic [2:0]            bsel_ff, bsel_in;
   logic                  hit_ff, hit_in;

   // set row decode
   logic [ROW-1:0]        row_q, row_aged;
   logic [1:0]            st [WAYS];
   logic [TAG_BITS-1:0]   tg [WAYS];
   logic [AGE_BITS-1:0]   ag_n [WAYS];
   logic                  hit_found, inv_found;
   logic [WAY_BITS-1:0]   hit_way, inv_way, old_way, vic;
   logic [AGE_BITS-1:0]   old_age;

   logic [INDEX_BITS-1:0] cset, pset;
   logic [TAG_BITS-1:0]   ctag, ptag;
   logic [WB-1:0]         cword, pword;

   assign cset  = get_set(cur_ff.addr);
   assign ctag  = get_tag(cur_ff.addr);
   assign cword = get_word(cur_ff.addr);
   assign pset  = get_set(pend_addr_ff);
   assign ptag  = get_tag(pend_addr_ff);
   assign pword = get_word(pend_addr_ff);
   assign row_q = rowv_rd_ff ? row_rd_ff : '0;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         logic [AGE_BITS-1:0] a;
         st[w] = row_q[w*ENT +: 2];
         tg[w] = row_q[w*ENT+2 +: TAG_BITS];
         a     = row_q[w*ENT+2+TAG_BITS +: AGE_BITS];
         ag_n[w] = (a == AGE_MAX) ? a : a + 1'b1;
         row_aged[w*ENT +: ENT] = {ag_n[w], tg[w], st[w]};
      end
   end

   always_comb begin
      hit_found = 1'b0;
      hit_way   = '0;
      inv_found = 1'b0;
      inv_way   = '0;
      old_way   = '0;
      old_age   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (w == 0 || ag_n[w] > old_age) begin
            old_age = ag_n[w];
            old_way = WAY_BITS'(w);
         end
         if (st[w] == ST_INV) begin
            inv_found = 1'b1;
            inv_way   = WAY_BITS'(w);
         end else if (!hit_found && tg[w] == ctag) begin
            hit_found = 1'b1;
            hit_way   = WAY_BITS'(w);
         end
      end
      vic = inv_found ? inv_way : old_way;
   end

   always_comb begin
      state_in     = state_ff;
      miss_in      = miss_ff;
      fill_cnt_in  = fill_cnt_ff;
      pend_way_in  = pend_way_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      way_in       = way_ff;
      vaddr_in     = vaddr_ff;
      pend_addr_in = pend_addr_ff;
      pend_wr_in   = pend_wr_ff;
      pend_byte_in = pend_byte_ff;
      bsel_in      = bsel_ff;
      hit_in       = hit_ff;
      q_pop        = 1'b0;
      rsp_push     = 1'b0;
      rsp_item     = '0;
      row_re       = 1'b0;
      row_raddr    = cset;
      row_we       = 1'b0;
      row_waddr    = cset;
      row_wdata    = row_aged;
      data_re      = 1'b0;
      data_raddr   = '0;
      data_we      = 1'b0;
      data_waddr   = '0;
      data_wdata   = '0;
      data_be      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && !rsp_full) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               if (q_head.cls == CLS_FILL && miss_ff) begin
                  data_we    = 1'b1;
                  data_waddr = data_idx(pset, pend_way_ff, fill_cnt_ff);
                  data_wdata = q_head.fword;
                  data_be    = '1;
                  if (fill_cnt_ff == LAST_WORD) begin
                     fill_cnt_in = '0;
                     row_re      = 1'b1;
                     row_raddr   = pset;
                     state_in    = S_FUPD;
                  end else begin
                     fill_cnt_in = fill_cnt_ff + 1'b1;
                  end
               end else if (q_head.cls == CLS_BAD || q_head.cls == CLS_FILL || miss_ff) begin
                  rsp_push      = 1'b1;
                  rsp_item.kind = KIND_REJ;
                  rsp_item.last = 1'b1;
               end else begin
                  row_re    = 1'b1;
                  row_raddr = get_set(q_head.addr);
                  state_in  = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            if (hit_found) begin
               row_wdata[int'(hit_way)*ENT+2+TAG_BITS +: AGE_BITS] = '0;
               if (cur_ff.cls == CLS_WRITE) begin
                  row_wdata[int'(hit_way)*ENT +: 2] = ST_DIRTY;
                  if (!rsp_full) begin
                     row_we        = 1'b1;
                     data_we       = 1'b1;
                     data_waddr    = data_idx(cset, hit_way, cword);
                     data_wdata    = {8{cur_ff.wbyte}};
                     data_be       = 8'd1 << cur_ff.addr[2:0];
                     rsp_push      = 1'b1;
                     rsp_item.kind = KIND_WRITE;
                     rsp_item.hit  = 1'b1;
                     rsp_item.last = 1'b1;
                     state_in      = S_IDLE;
                  end
               end else begin
                  row_we     = 1'b1;
                  data_re    = 1'b1;
                  data_raddr = data_idx(cset, hit_way, cword);
                  bsel_in    = cur_ff.addr[2:0];
                  hit_in     = 1'b1;
                  state_in   = S_RDOUT;
               end
            end else begin
               row_wdata[int'(vic)*ENT +: 2] = ST_INV;
               row_we = 1'b1;
               way_in = vic;
               cnt_in = '0;
               if (st[vic] == ST_DIRTY) begin
                  vaddr_in = vic_addr(tg[vic], cset);
                  state_in = S_WBRD;
               end else begin
                  state_in = S_FREQ;
               end
            end
         end
         S_WBRD: begin
            data_re    = 1'b1;
            data_raddr = data_idx(cset, way_ff, cnt_ff);
            state_in   = S_WBOUT;
         end
         S_WBOUT: begin
            if (!rsp_full) begin
               rsp_push       = 1'b1;
               rsp_item.kind  = KIND_WB;
               rsp_item.maddr = vaddr_ff;
               rsp_item.mword = data_rd_ff;
               rsp_item.last  = (cnt_ff == LAST_WORD);
               if (cnt_ff == LAST_WORD) begin
                  state_in = S_FREQ;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_WBRD;
               end
            end
         end
         S_FREQ: begin
            if (!rsp_full) begin
               rsp_push       = 1'b1;
               rsp_item.kind  = KIND_FREQ;
               rsp_item.maddr = {cur_ff.addr[31:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
               rsp_item.last  = 1'b1;
               miss_in        = 1'b1;
               pend_addr_in   = cur_ff.addr;
               pend_wr_in     = (cur_ff.cls == CLS_WRITE);
               pend_byte_in   = cur_ff.wbyte;
               pend_way_in    = way_ff;
               fill_cnt_in    = '0;
               state_in       = S_IDLE;
            end
         end
         S_FUPD: begin
            row_waddr = pset;
            row_wdata = row_q;
            row_wdata[int'(pend_way_ff)*ENT +: ENT] =
               {{AGE_BITS{1'b0}}, ptag, pend_wr_ff ? ST_DIRTY : ST_CLEAN};
            if (pend_wr_ff) begin
               if (!rsp_full) begin
                  row_we        = 1'b1;
                  data_we       = 1'b1;
                  data_waddr    = data_idx(pset, pend_way_ff, pword);
                  data_wdata    = {8{pend_byte_ff}};
                  data_be       = 8'd1 << pend_addr_ff[2:0];
                  rsp_push      = 1'b1;
                  rsp_item.kind = KIND_WRITE;
                  rsp_item.last = 1'b1;
                  miss_in       = 1'b0;
                  state_in      = S_IDLE;
               end
            end else begin
               row_we     = 1'b1;
               data_re    = 1'b1;
               data_raddr = data_idx(pset, pend_way_ff, pword);
               bsel_in    = pend_addr_ff[2:0];
               hit_in     = 1'b0;
               miss_in    = 1'b0;
               state_in   = S_RDOUT;
            end
         end
         S_RDOUT: begin
            if (!rsp_full) begin
               rsp_push       = 1'b1;
               rsp_item.kind  = KIND_READ;
               rsp_item.rbyte = data_rd_ff[{bsel_ff, 3'b000} +: 8];
               rsp_item.hit   = hit_ff;
               rsp_item.last  = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         miss_ff     <= 1'b0;
         fill_cnt_ff <= '0;
         pend_way_ff <= '0;
         rowv_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         miss_ff     <= miss_in;
         fill_cnt_ff <= fill_cnt_in;
         pend_way_ff <= pend_way_in;
         if (row_we) begin
            rowv_ff[row_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cnt_ff       <= cnt_in;
      way_ff       <= way_in;
      vaddr_ff     <= vaddr_in;
      pend_addr_ff <= pend_addr_in;
      pend_wr_ff   <= pend_wr_in;
      pend_byte_ff <= pend_byte_in;
      bsel_ff      <= bsel_in;
      hit_ff       <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         set_mem[row_waddr] <= row_wdata;
      end
      if (row_re) begin
         row_rd_ff  <= set_mem[row_raddr];
         rowv_rd_ff <= rowv_ff[row_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         for (int b = 0; b < 8; b++) begin
            if (data_be[b]) begin
               data_mem[data_waddr][b*8 +: 8] <= data_wdata[b*8 +: 8];
            end
         end
      end
      if (data_re) begin
         data_rd_ff <= data_mem[data_raddr];
      end
   end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Set-associative write-back cache: testbench
// Drives byte reads, byte writes, fill words and bad modes into the cache
// and checks every response against a cycle-free model of tags, ages,
// status and data. The stimulus runs through several idle and stall phases.
// ----------------------------------------------------------------------------
module tb;
   import sacl_pkg::*;

   localparam int NWAYS = 8;
   localparam int NSETS = 64;
   localparam int LWORDS = 8;
   localparam int LIMIT = 2000000;
   localparam logic [1:0] MODE_BAD = 2'd3;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] addr;
      logic [7:0]  wbyte;
      logic [63:0] fword;
   } access_type;

   typedef struct {
      kind_type    kind;
      logic [7:0]  rbyte;
      logic        hit;
      logic [31:0] maddr;
      logic [63:0] mword;
      logic        last;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [MODE_BITS-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [KIND_BITS-1:0] rsp_tuser;
   logic rsp_tlast;

   set_assoc_writeback_cache_lru u_top (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // model state
   logic [1:0]  m_status [NSETS*NWAYS];
   logic [19:0] m_tag    [NSETS*NWAYS];
   logic [15:0] m_age    [NSETS*NWAYS];
   logic [63:0] m_data   [NSETS*NWAYS*LWORDS];
   logic        m_pending;
   logic        m_pwr;
   logic [31:0] m_paddr;
   logic [7:0]  m_pbyte;
   int          m_pway;
   int          m_fcount;

   access_type pending_accesses[$];
   result_type expected_results[$];
   int errors = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 0;
   bit stim_done = 0;
   int cycles = 0;

   function automatic result_type mk(kind_type k, logic [7:0] rb, logic h,
                                     logic [31:0] ma, logic [63:0] mw, logic l);
      result_type r;
      r.kind = k; r.rbyte = rb; r.hit = h; r.maddr = ma; r.mword = mw; r.last = l;
      return r;
   endfunction

   function automatic logic [7:0] touch(int line, logic [31:0] a, logic wr,
                                        logic [7:0] b);
      int w;
      int sh;
      w = line*LWORDS + int'(a[5:3]);
      sh = int'(a[2:0])*8;
      if (wr) begin
         m_data[w][sh +: 8] = b;
         m_status[line] = ST_DIRTY;
         return 8'd0;
      end
      return m_data[w][sh +: 8];
   endfunction

   task automatic predict_cache(access_type a);
      int set;
      int base;
      int hitway;
      int invway;
      int oldway;
      logic [15:0] oldage;
      int line;
      logic [7:0] rb;
      logic [31:0] vaddr;
      logic wr;
      if (a.mode == MODE_FILL && m_pending) begin
         line = int'(m_paddr[11:6])*NWAYS + m_pway;
         m_data[line*LWORDS + m_fcount] = a.fword;
         m_fcount++;
         if (m_fcount < LWORDS) return;
         m_fcount = 0;
         m_pending = 0;
         m_tag[line] = m_paddr[31:12];
         m_age[line] = 0;
         m_status[line] = ST_CLEAN;
         rb = touch(line, m_paddr, m_pwr, m_pbyte);
         expected_results.push_back(mk(m_pwr ? KIND_WRITE : KIND_READ, rb, 0, 0, 0, 1));
         return;
      end
      if (a.mode > MODE_WRITE || m_pending) begin
         expected_results.push_back(mk(KIND_REJ, 0, 0, 0, 0, 1));
         return;
      end
      wr = (a.mode == MODE_WRITE);
      set = int'(a.addr[11:6]);
      base = set*NWAYS;
      hitway = -1; invway = -1; oldway = 0; oldage = 0;
      for (int w = 0; w < NWAYS; w++) begin
         if (m_age[base+w] != 16'hFFFF) m_age[base+w]++;
         if (w == 0 || m_age[base+w] > oldage) begin
            oldage = m_age[base+w]; oldway = w;
         end
         if (m_status[base+w] == ST_INV) invway = w;
         else if (hitway < 0 && m_tag[base+w] == a.addr[31:12]) hitway = w;
      end
      if (hitway >= 0) begin
         m_age[base+hitway] = 0;
         rb = touch(base+hitway, a.addr, wr, a.wbyte);
         expected_results.push_back(mk(wr ? KIND_WRITE : KIND_READ, rb, 1, 0, 0, 1));
         return;
      end
      m_pway = (invway >= 0) ? invway : oldway;
      line = base + m_pway;
      if (m_status[line] == ST_DIRTY) begin
         vaddr = {m_tag[line], set[5:0], 6'd0};
         for (int i = 0; i < LWORDS; i++)
            expected_results.push_back(mk(KIND_WB, 0, 0, vaddr, m_data[line*LWORDS+i],
                                          i == LWORDS-1));
      end
      m_status[line] = ST_INV;
      expected_results.push_back(mk(KIND_FREQ, 0, 0, {a.addr[31:6], 6'd0}, 0, 1));
      m_pending = 1;
      m_pwr = wr;
      m_paddr = a.addr;
      m_pbyte = a.wbyte;
      m_fcount = 0;
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      access_type a;
      if (!reset) begin
         if (req_tvalid && req_tready) predict_cache(pending_accesses.pop_front());
         if ((!req_tvalid || req_tready)) begin
            if (pending_accesses.size() > 0 && !hold_off &&
                $urandom_range(99, 0) >= idle_pct) begin
               a = pending_accesses[0];
               req_tvalid <= 1;
               req_tdata <= {a.fword, a.wbyte, a.addr};
               req_tuser <= a.mode;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type w;
      logic [7:0] rb;
      logic h;
      logic [31:0] ma;
      logic [63:0] mw;
      if (!reset) begin
         rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            {mw, ma, h, rb} = rsp_tdata[104:0];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", rsp_tuser, 0);
            end else begin
               w = expected_results.pop_front();
               if (rsp_tuser != w.kind) report_mismatch("kind", rsp_tuser, w.kind);
               if (rb != w.rbyte) report_mismatch("read_byte", rb, w.rbyte);
               if (h != w.hit) report_mismatch("hit", h, w.hit);
               if (ma != w.maddr) report_mismatch("mem_address", ma, w.maddr);
               if (mw != w.mword) report_mismatch("mem_word", mw, w.mword);
               if (rsp_tlast != w.last) report_mismatch("last", rsp_tlast, w.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // small tag pool so sets fill up, age out and evict dirty lines
   function automatic logic [31:0] pick_addr();
      logic [31:0] a;
      a = $urandom;
      a[31:12] = ($urandom_range(3, 0) == 0) ? a[31:12] : 20'(($urandom_range(11, 0)) * 20'h1357B);
      if ($urandom_range(1, 0)) a[11:6] = 6'($urandom_range(3, 0));
      return a;
   endfunction

   task automatic queue_access(logic [1:0] mode, logic [31:0] addr, logic [7:0] b,
                               logic [63:0] fw);
      access_type a;
      a.mode = mode; a.addr = addr; a.wbyte = b; a.fword = fw;
      pending_accesses.push_back(a);
   endtask

   // the eight fill words of a miss
   task automatic queue_fill();
      for (int i = 0; i < LWORDS; i++)
         queue_access(MODE_FILL, $urandom, 8'($urandom), rand64());
   endtask

   task automatic queue_miss(logic [1:0] mode, logic [31:0] addr, logic [7:0] b);
      queue_access(mode, addr, b, rand64());
      queue_fill();
   endtask

   task automatic drain();
      while (pending_accesses.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // generator miss-state variables; queue_random does not use them
   bit gen_pending;
   int gen_fills;

   task automatic queue_random();
      int r;
      r = $urandom_range(99, 0);
      if (r < 4) begin
         queue_access(MODE_BAD, $urandom, 8'($urandom), rand64());
      end else if (r < 8) begin
         queue_access(MODE_FILL, $urandom, 8'($urandom), rand64());
      end else if (r < 11) begin
         queue_access(2'($urandom_range(1, 0)), pick_addr(), 8'($urandom), rand64());
         queue_fill();
         queue_access(MODE_FILL, $urandom, 8'($urandom), rand64());
      end else begin
         queue_access(2'($urandom_range(1, 0)), pick_addr(), 8'($urandom), rand64());
         // fills are harmless on a hit (rejected), needed on a miss
         if ($urandom_range(1, 0)) queue_fill();
      end
   endtask

   initial begin
      foreach (m_status[i]) begin
         m_status[i] = ST_INV; m_tag[i] = 0; m_age[i] = 0;
      end
      foreach (m_data[i]) m_data[i] = 0;
      m_pending = 0; m_pwr = 0; m_paddr = 0; m_pbyte = 0; m_pway = 0; m_fcount = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed: extremes, all modes, rejections, dirty eviction in one set
      queue_access(MODE_FILL, 32'h0, 8'h0, 64'h0);
      queue_access(MODE_BAD, 32'hFFFF_FFFF, 8'hFF, '1);
      queue_miss(MODE_WRITE, 32'hFFFF_FFFF, 8'hA5);
      queue_access(MODE_READ, 32'hFFFF_FFFF, 8'h0, 64'h0);
      queue_access(MODE_WRITE, 32'hFFFF_FFC0, 8'hFF, '1);
      queue_access(MODE_READ, 32'h0, 8'h0, 64'h0);
      queue_access(MODE_READ, 32'h0, 8'h0, 64'h0);
      for (int i = 0; i < LWORDS; i++) queue_access(MODE_FILL, 32'h0, 8'h0, '1);
      queue_access(MODE_READ, 32'h0000_0007, 8'h0, 64'h0);
      for (int t = 1; t <= 9; t++) queue_miss(MODE_WRITE, {20'(t), 6'd63, 6'(t)}, 8'(t));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 17) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 67 : 17) : 0;
         for (int n = 0; n < 14; n++) queue_random();
         drain();
         hold_off = 1;
         repeat (5) @(posedge clock);
         hold_off = 0;
         idle_pct = 0; stall_pct = 0;
         for (int n = 0; n < 4; n++) queue_random();
         drain();
      end

      if (expected_results.size() == 0 && errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
